FILE: hw/rtl/euler_pose_to_transform_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef EULER_POSE_TO_TRANSFORM_MACROS_SVH
`define EULER_POSE_TO_TRANSFORM_MACROS_SVH

// same-cycle implication
`define EPT_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define EPT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: hw/rtl/ept_pkg.sv
package ept_pkg;

   localparam int unsigned POS_W   = 32;
   localparam int unsigned ANGLE_W = 16;
   localparam int unsigned COEF_W  = 16;
   localparam int unsigned TRIG_W  = 32;
   localparam int unsigned PROD_W  = 64;
   localparam int unsigned N_COEF  = 9;

   localparam int unsigned TBL_DEPTH = 2881;
   localparam int unsigned TBL_AW    = 12;
   localparam int unsigned TBL_DW    = 62;
   localparam int unsigned HALF_DW   = 31;

   localparam logic signed [16:0] FULL_TURN    = 17'sd23040;
   localparam logic [14:0]        QUARTER_TURN = 15'd5760;
   localparam logic [14:0]        EIGHTH_TURN  = 15'd2880;
   localparam logic [TBL_AW-1:0]  LAST_T       = 12'd2880;

   localparam logic [63:0] PI_Q62    = 64'hC90FDAA22168C235;
   localparam logic [63:0] UNIT_STEP = PI_Q62 / 64'd11520;
   localparam logic [63:0] ONE_Q62   = 64'h4000000000000000;
   localparam int unsigned N_TERMS   = 10;
   localparam logic [3:0]  SERIES_TERMS = 4'(N_TERMS);

   // floor(n / d) for n < 2**63 and d <= 512 is (n * m) >> DIV_SH,
   // with m = 2**DIV_SH / d + 1
   localparam int unsigned DIV_SH = 72;
   localparam int unsigned MAG_W  = 72;

   localparam int unsigned LANE_LAT  = 3;
   localparam int unsigned MERGE_LAT = 5;
   localparam int unsigned LATENCY   = LANE_LAT + MERGE_LAT;

   typedef logic signed [TRIG_W-1:0] trig_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic [N_TERMS:1][MAG_W-1:0] magic_tbl_type;

   typedef struct packed {
      logic              en;
      logic [TBL_AW-1:0] addr;
      logic [TBL_DW-1:0] data;
   } ept_wr_type;

   function automatic prod_type mul_trig(trig_type a, trig_type b);
      prod_type x;
      prod_type y;
      x = a;
      y = b;
      return x * y;
   endfunction

   // round right by s, to nearest, ties away from zero
   function automatic prod_type rnd_shift(prod_type v, int unsigned s);
      logic [PROD_W-1:0] half;
      logic [PROD_W-1:0] mag;
      logic [PROD_W-1:0] r;
      half = 64'd1 << (s - 1);
      mag  = v[PROD_W-1] ? 64'(-v) : 64'(v);
      r    = (mag + half) >> s;
      return v[PROD_W-1] ? -prod_type'(r) : prod_type'(r);
   endfunction

   function automatic logic [MAG_W-1:0] div_magic(int unsigned d);
      logic [MAG_W:0] p;
      p         = '0;
      p[DIV_SH] = 1'b1;
      return MAG_W'(p / (MAG_W + 1)'(d) + 1'b1);
   endfunction

   // sine steps divide by 2k(2k+1), cosine steps by (2k-1)2k
   function automatic magic_tbl_type magic_tbl(logic sin_div);
      magic_tbl_type m;
      for (int unsigned k = 1; k <= N_TERMS; k++) begin
         m[k] = sin_div ? div_magic(2 * k * (2 * k + 1))
                        : div_magic((2 * k - 1) * 2 * k);
      end
      return m;
   endfunction

   localparam magic_tbl_type MAGIC_SIN = magic_tbl(1'b1);
   localparam magic_tbl_type MAGIC_COS = magic_tbl(1'b0);

endpackage

FILE: hw/rtl/ept_init.sv
`include "euler_pose_to_transform_macros.svh"

module ept_init import ept_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   output ept_wr_type wr,
   output logic       done
);

   typedef enum logic [4:0] {
      S_SQR   = 5'b00001,
      S_MUL   = 5'b00010,
      S_DIV   = 5'b00100,
      S_WRITE = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [TBL_AW-1:0] t_ff, t_in;
   logic [3:0]        k_ff, k_in;
   logic [5:0]        cnt_ff, cnt_in;
   logic [63:0]       x_ff, x_in, x2_ff, x2_in;
   logic [63:0]       st_ff, st_in, ct_ff, ct_in, ss_ff, ss_in, cs_ff, cs_in;
   logic [135:0]      acs_ff, acs_in, acc_ff, acc_in;

   logic             b_s, b_c;
   logic [MAG_W-1:0] ms, mc;
   logic [135:0]     ma_s, ma_c, sum_s, sum_c;
   logic [63:0]      q_s, q_c, x_nx, sin_r, cos_r;

   // one shift-add engine: x*x, then per term the series product and the
   // division, done as a product with the reciprocal of the step divisor
   always_comb begin
      ms    = MAGIC_SIN[k_ff];
      mc    = MAGIC_COS[k_ff];
      b_s   = (state_ff == S_SQR) ? x_ff[~cnt_ff] :
              (state_ff == S_DIV) ? st_ff[~cnt_ff] : x2_ff[~cnt_ff];
      b_c   = (state_ff == S_DIV) ? ct_ff[~cnt_ff] : x2_ff[~cnt_ff];
      ma_s  = (state_ff == S_SQR) ? {72'd0, x_ff} :
              (state_ff == S_DIV) ? {64'd0, ms} : {72'd0, st_ff};
      ma_c  = (state_ff == S_DIV) ? {64'd0, mc} : {72'd0, ct_ff};
      sum_s = {acs_ff[134:0], 1'b0} + (b_s ? ma_s : 136'd0);
      sum_c = {acc_ff[134:0], 1'b0} + (b_c ? ma_c : 136'd0);
      q_s   = sum_s[DIV_SH +: 64];
      q_c   = sum_c[DIV_SH +: 64];

      x_nx  = x_ff + UNIT_STEP;
      sin_r = ss_ff + 64'h80000000;
      cos_r = cs_ff + 64'h80000000;
   end

   always_comb begin
      state_in = state_ff;
      t_in     = t_ff;
      k_in     = k_ff;
      cnt_in   = cnt_ff;
      x_in     = x_ff;
      x2_in    = x2_ff;
      st_in    = st_ff;
      ct_in    = ct_ff;
      ss_in    = ss_ff;
      cs_in    = cs_ff;
      acs_in   = acs_ff;
      acc_in   = acc_ff;
      wr.en    = 1'b0;
      wr.addr  = t_ff;
      wr.data  = {sin_r[62:32], cos_r[62:32]};
      case (state_ff)
         S_SQR: begin
            acs_in = sum_s;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               x2_in    = sum_s[125:62];
               acs_in   = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            acs_in = sum_s;
            acc_in = sum_c;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               st_in    = sum_s[125:62];
               ct_in    = sum_c[125:62];
               acs_in   = '0;
               acc_in   = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            acs_in = sum_s;
            acc_in = sum_c;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               st_in  = q_s;
               ct_in  = q_c;
               acs_in = '0;
               acc_in = '0;
               // alternating signs of the series
               ss_in = k_ff[0] ? ss_ff - q_s : ss_ff + q_s;
               cs_in = k_ff[0] ? cs_ff - q_c : cs_ff + q_c;
               if (k_ff == SERIES_TERMS) begin
                  state_in = S_WRITE;
               end else begin
                  k_in     = k_ff + 4'd1;
                  state_in = S_MUL;
               end
            end
         end
         S_WRITE: begin
            wr.en = 1'b1;
            if (t_ff == LAST_T) begin
               state_in = S_DONE;
            end else begin
               t_in     = t_ff + 12'd1;
               x_in     = x_nx;
               st_in    = x_nx;
               ss_in    = x_nx;
               ct_in    = ONE_Q62;
               cs_in    = ONE_Q62;
               k_in     = 4'd1;
               state_in = S_SQR;
            end
         end
         S_DONE: begin
            state_in = S_DONE;
         end
         default: begin
            state_in = S_DONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_SQR;
         t_ff     <= '0;
         k_ff     <= 4'd1;
         cnt_ff   <= '0;
         x_ff     <= '0;
         st_ff    <= '0;
         ss_ff    <= '0;
         ct_ff    <= ONE_Q62;
         cs_ff    <= ONE_Q62;
         acs_ff   <= '0;
         acc_ff   <= '0;
      end else begin
         state_ff <= state_in;
         t_ff     <= t_in;
         k_ff     <= k_in;
         cnt_ff   <= cnt_in;
         x_ff     <= x_in;
         st_ff    <= st_in;
         ss_ff    <= ss_in;
         ct_ff    <= ct_in;
         cs_ff    <= cs_in;
         acs_ff   <= acs_in;
         acc_ff   <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      x2_ff <= x2_in;
   end

   assign done = (state_ff == S_DONE);

   `EPT_ASSERT_IMPL(a_wr_range, clock, reset, wr.en, wr.addr <= LAST_T)
   `EPT_ASSERT_NEXT(a_done_sticky, clock, reset, done, done && !wr.en)
   `EPT_ASSERT_IMPL(a_div_k, clock, reset, state_ff == S_DIV, k_ff >= 4'd1 && k_ff <= SERIES_TERMS)

endmodule

FILE: hw/rtl/ept_lane.sv
module ept_lane import ept_pkg::*; (
   input  logic                      clock,
   input  ept_wr_type                wr,
   input  logic signed [ANGLE_W-1:0] angle,
   output trig_type                  sin_out,
   output trig_type                  cos_out
);

   typedef enum logic [1:0] {
      QUAD_I   = 2'd0,
      QUAD_II  = 2'd1,
      QUAD_III = 2'd2,
      QUAD_IV  = 2'd3
   } quad_type;

   logic [TBL_DW-1:0] mem [TBL_DEPTH];

   logic signed [16:0] a_ext, r_s;
   logic [14:0]        r_u, rem;
   quad_type           q_c;
   logic [TBL_AW-1:0]  t_c;
   logic               sw_c;

   logic [TBL_AW-1:0] t_ff;
   quad_type          q_ff, q2_ff;
   logic              sw_ff, sw2_ff;
   logic [TBL_DW-1:0] rd_ff;
   trig_type          sv, cv, s0, c0;
   trig_type          s_ff, c_ff;

   // wrap to 0..full turn, split into quadrant, fold into the first octant
   always_comb begin
      a_ext = 17'(angle);
      if (a_ext < 0) begin
         r_s = a_ext + FULL_TURN;
         if (r_s < 0) begin
            r_s = r_s + FULL_TURN;
         end
      end else if (a_ext >= FULL_TURN) begin
         r_s = a_ext - FULL_TURN;
      end else begin
         r_s = a_ext;
      end
      r_u = r_s[14:0];
      if (r_u < QUARTER_TURN) begin
         q_c = QUAD_I;
         rem = r_u;
      end else if (r_u < 15'(2 * QUARTER_TURN)) begin
         q_c = QUAD_II;
         rem = r_u - QUARTER_TURN;
      end else if (r_u < 15'(3 * QUARTER_TURN)) begin
         q_c = QUAD_III;
         rem = r_u - 15'(2 * QUARTER_TURN);
      end else begin
         q_c = QUAD_IV;
         rem = r_u - 15'(3 * QUARTER_TURN);
      end
      sw_c = rem > EIGHTH_TURN;
      t_c  = sw_c ? 12'(QUARTER_TURN - rem) : rem[TBL_AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_ff  <= mem[t_ff];
      t_ff   <= t_c;
      q_ff   <= q_c;
      sw_ff  <= sw_c;
      q2_ff  <= q_ff;
      sw2_ff <= sw_ff;
   end

   always_comb begin
      sv = trig_type'({1'b0, rd_ff[TBL_DW-1:HALF_DW]});
      cv = trig_type'({1'b0, rd_ff[HALF_DW-1:0]});
      s0 = sw2_ff ? cv : sv;
      c0 = sw2_ff ? sv : cv;
   end

   always_ff @(posedge clock) begin
      case (q2_ff)
         QUAD_I: begin
            s_ff <= s0;
            c_ff <= c0;
         end
         QUAD_II: begin
            s_ff <= c0;
            c_ff <= -s0;
         end
         QUAD_III: begin
            s_ff <= -s0;
            c_ff <= -c0;
         end
         default: begin
            s_ff <= -c0;
            c_ff <= s0;
         end
      endcase
   end

   assign sin_out = s_ff;
   assign cos_out = c_ff;

endmodule

FILE: hw/rtl/ept_merge.sv
module ept_merge import ept_pkg::*; #(
   parameter int unsigned COEF_FRAC_BITS = 14
) (
   input  logic                         clock,
   input  trig_type                     sx,
   input  trig_type                     cx,
   input  trig_type                     sy,
   input  trig_type                     cy,
   input  trig_type                     sz,
   input  trig_type                     cz,
   output logic [N_COEF-1:0][COEF_W-1:0] coef
);

   localparam int unsigned OUT_SHIFT = 60 - COEF_FRAC_BITS;

   typedef struct packed {
      prod_type cycz, cysz, sy60, sxcy, cxcy, sxsz, cxsz, cxcz, sxcz;
   } direct_type;

   direct_type a_ff, b_ff, c_ff;
   prod_type   a_sxsy_ff, a_cxsy_ff;
   trig_type   a_sz_ff, a_cz_ff, b_sz_ff, b_cz_ff;
   trig_type   b_sxsy_ff, b_cxsy_ff;
   prod_type   m1_ff, m2_ff, m3_ff, m4_ff;
   prod_type   e_ff [N_COEF];
   logic [N_COEF-1:0][COEF_W-1:0] o_ff;
   prod_type   sy_ext;
   prod_type   rr [N_COEF];

   assign sy_ext = sy;

   always_ff @(posedge clock) begin
      a_ff.cycz <= mul_trig(cy, cz);
      a_ff.cysz <= mul_trig(cy, sz);
      a_ff.sy60 <= sy_ext <<< 30;
      a_ff.sxcy <= mul_trig(sx, cy);
      a_ff.cxcy <= mul_trig(cx, cy);
      a_ff.sxsz <= mul_trig(sx, sz);
      a_ff.cxsz <= mul_trig(cx, sz);
      a_ff.cxcz <= mul_trig(cx, cz);
      a_ff.sxcz <= mul_trig(sx, cz);
      a_sxsy_ff <= mul_trig(sx, sy);
      a_cxsy_ff <= mul_trig(cx, sy);
      a_sz_ff   <= sz;
      a_cz_ff   <= cz;

      // triple products take a Q30 rounding of the sy pair first
      b_ff      <= a_ff;
      b_sxsy_ff <= trig_type'(rnd_shift(a_sxsy_ff, 30));
      b_cxsy_ff <= trig_type'(rnd_shift(a_cxsy_ff, 30));
      b_sz_ff   <= a_sz_ff;
      b_cz_ff   <= a_cz_ff;

      c_ff  <= b_ff;
      m1_ff <= mul_trig(b_sxsy_ff, b_cz_ff);
      m2_ff <= mul_trig(b_sxsy_ff, b_sz_ff);
      m3_ff <= mul_trig(b_cxsy_ff, b_cz_ff);
      m4_ff <= mul_trig(b_cxsy_ff, b_sz_ff);

      e_ff[0] <= c_ff.cycz;
      e_ff[1] <= -c_ff.cysz;
      e_ff[2] <= c_ff.sy60;
      e_ff[3] <= m1_ff + c_ff.cxsz;
      e_ff[4] <= c_ff.cxcz - m2_ff;
      e_ff[5] <= -c_ff.sxcy;
      e_ff[6] <= c_ff.sxsz - m3_ff;
      e_ff[7] <= m4_ff + c_ff.sxcz;
      e_ff[8] <= c_ff.cxcy;
   end

   always_comb begin
      for (int i = 0; i < N_COEF; i++) begin
         rr[i] = rnd_shift(e_ff[i], OUT_SHIFT);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < N_COEF; i++) begin
         if (rr[i] > 64'sd32767) begin
            o_ff[i] <= 16'h7FFF;
         end else if (rr[i] < -64'sd32768) begin
            o_ff[i] <= 16'h8000;
         end else begin
            o_ff[i] <= rr[i][COEF_W-1:0];
         end
      end
   end

   assign coef = o_ff;

endmodule

FILE: hw/rtl/euler_pose_to_transform.sv
// Euler pose to 3x4 rigid transform, R = Rx * Ry * Rz.
// Request: pulse start with req_pos_* (Q16.16) and req_angle_* (1/64 degree)
// while busy is low; the item is taken at that edge. One item per cycle.
// Response: rsp_valid is high for one cycle with the nine Q2.14 rotation
// entries rsp_r00..rsp_r22 and the translation rsp_out_* passed through.
// Each angle lane registers wrap and fold, table read and quadrant fix-up;
// the matrix stage then registers products, Q30 rounding of the sy pairs,
// triple products, sums, and final rounding and saturation.
// Throughput is one item per clock cycle once busy is low, fully pipelined.
// After reset, busy stays high while the sine/cosine table is built by a
// serial series evaluator, one of its 2881 entries at a time. Items issued
// before busy falls are not taken.
// Results cannot be held off; the receiver must take each one as it comes.
// Reset also drops any items still in flight.
`include "euler_pose_to_transform_macros.svh"

module euler_pose_to_transform import ept_pkg::*; #(
   parameter int unsigned COEF_FRAC_BITS = 14
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic signed [POS_W-1:0]   req_pos_x,
   input  logic signed [POS_W-1:0]   req_pos_y,
   input  logic signed [POS_W-1:0]   req_pos_z,
   input  logic signed [ANGLE_W-1:0] req_angle_x,
   input  logic signed [ANGLE_W-1:0] req_angle_y,
   input  logic signed [ANGLE_W-1:0] req_angle_z,
   output logic                      rsp_valid,
   output logic signed [COEF_W-1:0]  rsp_r00,
   output logic signed [COEF_W-1:0]  rsp_r01,
   output logic signed [COEF_W-1:0]  rsp_r02,
   output logic signed [COEF_W-1:0]  rsp_r10,
   output logic signed [COEF_W-1:0]  rsp_r11,
   output logic signed [COEF_W-1:0]  rsp_r12,
   output logic signed [COEF_W-1:0]  rsp_r20,
   output logic signed [COEF_W-1:0]  rsp_r21,
   output logic signed [COEF_W-1:0]  rsp_r22,
   output logic signed [POS_W-1:0]   rsp_out_x,
   output logic signed [POS_W-1:0]   rsp_out_y,
   output logic signed [POS_W-1:0]   rsp_out_z
);

   ept_wr_type wr;
   logic       done;
   logic       accept;
   trig_type   sx, cx, sy, cy, sz, cz;
   logic [N_COEF-1:0][COEF_W-1:0] coef;

   logic [LATENCY-1:0] vld_ff, vld_in;
   logic [POS_W-1:0]   px_ff [LATENCY];
   logic [POS_W-1:0]   py_ff [LATENCY];
   logic [POS_W-1:0]   pz_ff [LATENCY];

   assign busy   = reset | ~done;
   assign accept = start & ~busy;

   ept_init u_init (
      .clock (clock),
      .reset (reset),
      .wr    (wr),
      .done  (done)
   );

   ept_lane u_lane_x (
      .clock   (clock),
      .wr      (wr),
      .angle   (req_angle_x),
      .sin_out (sx),
      .cos_out (cx)
   );

   ept_lane u_lane_y (
      .clock   (clock),
      .wr      (wr),
      .angle   (req_angle_y),
      .sin_out (sy),
      .cos_out (cy)
   );

   ept_lane u_lane_z (
      .clock   (clock),
      .wr      (wr),
      .angle   (req_angle_z),
      .sin_out (sz),
      .cos_out (cz)
   );

   ept_merge #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_merge (
      .clock (clock),
      .sx    (sx),
      .cx    (cx),
      .sy    (sy),
      .cy    (cy),
      .sz    (sz),
      .cz    (cz),
      .coef  (coef)
   );

   assign vld_in = {vld_ff[LATENCY-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff[0] <= req_pos_x;
      py_ff[0] <= req_pos_y;
      pz_ff[0] <= req_pos_z;
      for (int i = 1; i < LATENCY; i++) begin
         px_ff[i] <= px_ff[i-1];
         py_ff[i] <= py_ff[i-1];
         pz_ff[i] <= pz_ff[i-1];
      end
   end

   assign rsp_valid = vld_ff[LATENCY-1];
   assign rsp_r00   = coef[0];
   assign rsp_r01   = coef[1];
   assign rsp_r02   = coef[2];
   assign rsp_r10   = coef[3];
   assign rsp_r11   = coef[4];
   assign rsp_r12   = coef[5];
   assign rsp_r20   = coef[6];
   assign rsp_r21   = coef[7];
   assign rsp_r22   = coef[8];
   assign rsp_out_x = px_ff[LATENCY-1];
   assign rsp_out_y = py_ff[LATENCY-1];
   assign rsp_out_z = pz_ff[LATENCY-1];

   `EPT_ASSERT_IMPL(a_no_rsp_in_init, clock, reset, !done, !rsp_valid && vld_ff == '0)
   `EPT_ASSERT_IMPL(a_rsp_follows_req, clock, reset, rsp_valid, $past(accept, LATENCY))
   `EPT_ASSERT_NEXT(a_req_enters, clock, reset, accept, vld_ff[0])

endmodule
